FILE: src/qte_pkg.sv
// Shared types, constants and the CORDIC angle table for the quaternion to Euler block.
`default_nettype none
package qte_pkg;

	localparam int CORDIC_ITERS_DEF    = 16;
	localparam int COMPONENT_WIDTH_DEF = 16;
	localparam int ATAN_STEPS          = 24;

	// CORDIC operand width at the atan2 input, working width after normalizing
	localparam int AW        = 36;
	localparam int CXW       = 33;
	localparam int ANG_W     = 27;
	localparam int NORM_BITS = 30;
	localparam int NORM_LAT  = 4;

	// floor square root of a Q60 radicand, one result bit per stage
	localparam int ISQ_STEPS = 31;
	localparam int RAD_W     = 61;
	localparam int ROOT_W    = 31;
	localparam int RR_W      = 63;

	localparam int Q30_ONE   = 1 << 30;
	localparam int DEG_ONE   = 65536;
	localparam int DEG90     = 90 * DEG_ONE;
	localparam int DEG180    = 180 * DEG_ONE;
	localparam int FULL_TURN = 360 * DEG_ONE;
	localparam int OUT_SHIFT = 10;

	localparam logic [1:0] POLE_NONE  = 2'd0;
	localparam logic [1:0] POLE_NORTH = 2'd1;
	localparam logic [1:0] POLE_SOUTH = 2'd2;

	typedef struct packed {
		logic signed [15:0] quat_x;
		logic signed [15:0] quat_y;
		logic signed [15:0] quat_z;
		logic signed [15:0] quat_w;
	} quat_t;

	typedef struct packed {
		logic signed [15:0] angle_x;
		logic signed [15:0] angle_y;
		logic signed [15:0] angle_z;
		logic [1:0]         pole_case;
	} euler_t;

	// atan(2^-i) in degrees, 16 fraction bits
	function automatic logic signed [ANG_W-1:0] atan_deg(input logic [4:0] idx);
		logic signed [ANG_W-1:0] v;
		case (idx)
			5'd0:    v = ANG_W'(2949120);
			5'd1:    v = ANG_W'(1740967);
			5'd2:    v = ANG_W'(919879);
			5'd3:    v = ANG_W'(466945);
			5'd4:    v = ANG_W'(234379);
			5'd5:    v = ANG_W'(117304);
			5'd6:    v = ANG_W'(58666);
			5'd7:    v = ANG_W'(29335);
			5'd8:    v = ANG_W'(14668);
			5'd9:    v = ANG_W'(7334);
			5'd10:   v = ANG_W'(3667);
			5'd11:   v = ANG_W'(1833);
			5'd12:   v = ANG_W'(917);
			5'd13:   v = ANG_W'(458);
			5'd14:   v = ANG_W'(229);
			5'd15:   v = ANG_W'(115);
			5'd16:   v = ANG_W'(57);
			5'd17:   v = ANG_W'(29);
			5'd18:   v = ANG_W'(14);
			5'd19:   v = ANG_W'(7);
			5'd20:   v = ANG_W'(4);
			5'd21:   v = ANG_W'(2);
			5'd22:   v = ANG_W'(1);
			default: v = '0;
		endcase
		return v;
	endfunction

endpackage
`default_nettype wire

FILE: src/qte_isqrt.sv
// Pipelined floor square root, one result bit per stage.
`default_nettype none
module qte_isqrt (
	input  wire logic                          clk,
	input  wire logic                          en,
	input  wire logic [qte_pkg::RAD_W-1:0]     rad,
	output logic      [qte_pkg::ROOT_W-1:0]    root
);
	localparam int STEPS  = qte_pkg::ISQ_STEPS;
	localparam int RAD_W  = qte_pkg::RAD_W;
	localparam int RR_W   = qte_pkg::RR_W;
	localparam int ROOT_W = qte_pkg::ROOT_W;

	logic [RAD_W-1:0] v_s [0:STEPS-1];
	logic [RR_W-1:0]  r_s [0:STEPS-1];

	for (genvar k = 0; k < STEPS; k++) begin : g_step
		localparam int SH = 2 * (STEPS - 1 - k);
		logic [RAD_W-1:0] v_in;
		logic [RR_W-1:0]  r_in;
		logic [RR_W-1:0]  bitv;
		logic [RR_W-1:0]  sum;

		if (k == 0) begin : g_first
			assign v_in = rad;
			assign r_in = '0;
		end else begin : g_next
			assign v_in = v_s[k-1];
			assign r_in = r_s[k-1];
		end

		assign bitv = RR_W'(1) << SH;
		assign sum  = r_in + bitv;

		always_ff @(posedge clk) begin
			if (en) begin
				if (RR_W'(v_in) >= sum) begin
					v_s[k] <= v_in - RAD_W'(sum);
					r_s[k] <= (r_in >> 1) + bitv;
				end else begin
					v_s[k] <= v_in;
					r_s[k] <= r_in >> 1;
				end
			end
		end
	end

	assign root = r_s[STEPS-1][ROOT_W-1:0];

endmodule
`default_nettype wire

FILE: src/qte_atan2.sv
// Pipelined atan2 in degrees: half-plane fold, normalize, vectoring CORDIC.
`default_nettype none
module qte_atan2 #(
	parameter int ITERS = qte_pkg::CORDIC_ITERS_DEF
) (
	input  wire logic                               clk,
	input  wire logic                               en,
	input  wire logic signed [qte_pkg::AW-1:0]      y,
	input  wire logic signed [qte_pkg::AW-1:0]      x,
	output logic      signed [qte_pkg::ANG_W-1:0]   angle
);
	localparam int AW    = qte_pkg::AW;
	localparam int CXW   = qte_pkg::CXW;
	localparam int ANG_W = qte_pkg::ANG_W;
	localparam int NB    = qte_pkg::NORM_BITS;
	localparam int BLW   = $clog2(AW + 1);

	logic                    zero_s1, zero_s2, zero_s3, zero_s4;
	logic signed [AW-1:0]    xa_s1, xa_s2, xa_s3;
	logic signed [AW-1:0]    ya_s1, ya_s2, ya_s3;
	logic signed [ANG_W-1:0] base_s1, base_s2, base_s3, base_s4;
	logic [AW-1:0]           m_s2;
	logic [BLW-1:0]          bl_s3;
	logic signed [CXW-1:0]   x0_s4, y0_s4;

	logic signed [AW-1:0]    yabs;
	logic [BLW-1:0]          bl;
	logic [BLW-1:0]          sr, sl;

	// fold the left half-plane onto the right one
	always_ff @(posedge clk) begin
		if (en) begin
			zero_s1 <= (x == '0) && (y == '0);
			if (x < 0) begin
				xa_s1   <= -x;
				ya_s1   <= -y;
				base_s1 <= (y >= 0) ? ANG_W'(qte_pkg::DEG180) : -ANG_W'(qte_pkg::DEG180);
			end else begin
				xa_s1   <= x;
				ya_s1   <= y;
				base_s1 <= '0;
			end
		end
	end

	assign yabs = (ya_s1 < 0) ? -ya_s1 : ya_s1;

	always_ff @(posedge clk) begin
		if (en) begin
			zero_s2 <= zero_s1;
			xa_s2   <= xa_s1;
			ya_s2   <= ya_s1;
			base_s2 <= base_s1;
			m_s2    <= (xa_s1 > yabs) ? $unsigned(xa_s1) : $unsigned(yabs);
		end
	end

	always_comb begin
		bl = '0;
		for (int i = 0; i < AW; i++) begin
			if (m_s2[i]) bl = BLW'(i + 1);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			zero_s3 <= zero_s2;
			xa_s3   <= xa_s2;
			ya_s3   <= ya_s2;
			base_s3 <= base_s2;
			bl_s3   <= bl;
		end
	end

	// bring the larger magnitude into [2^29, 2^30)
	assign sr = bl_s3 - BLW'(NB);
	assign sl = BLW'(NB) - bl_s3;

	always_ff @(posedge clk) begin
		if (en) begin
			zero_s4 <= zero_s3;
			base_s4 <= base_s3;
			if (bl_s3 > BLW'(NB)) begin
				x0_s4 <= CXW'(xa_s3 >>> sr);
				y0_s4 <= CXW'(ya_s3 >>> sr);
			end else begin
				x0_s4 <= CXW'(xa_s3 <<< sl);
				y0_s4 <= CXW'(ya_s3 <<< sl);
			end
		end
	end

	logic signed [CXW-1:0]   cx_s [0:ITERS-1];
	logic signed [CXW-1:0]   cy_s [0:ITERS-1];
	logic signed [ANG_W-1:0] cz_s [0:ITERS-1];
	logic                    cq_s [0:ITERS-1];

	for (genvar i = 0; i < ITERS; i++) begin : g_iter
		logic signed [CXW-1:0]   xi, yi;
		logic signed [ANG_W-1:0] zi;
		logic                    qi;

		if (i == 0) begin : g_first
			assign xi = x0_s4;
			assign yi = y0_s4;
			assign zi = base_s4;
			assign qi = zero_s4;
		end else begin : g_next
			assign xi = cx_s[i-1];
			assign yi = cy_s[i-1];
			assign zi = cz_s[i-1];
			assign qi = cq_s[i-1];
		end

		always_ff @(posedge clk) begin
			if (en) begin
				cq_s[i] <= qi;
				if (yi >= 0) begin
					cx_s[i] <= xi + (yi >>> i);
					cy_s[i] <= yi - (xi >>> i);
					cz_s[i] <= zi + qte_pkg::atan_deg(5'(i));
				end else begin
					cx_s[i] <= xi - (yi >>> i);
					cy_s[i] <= yi + (xi >>> i);
					cz_s[i] <= zi - qte_pkg::atan_deg(5'(i));
				end
			end
		end
	end

	assign angle = cq_s[ITERS-1] ? '0 : cz_s[ITERS-1];

endmodule
`default_nettype wire

FILE: src/quaternion_to_euler_angles.sv
// Quaternion to Euler angles with pole handling, fully pipelined top level.
//
// Input channel quat (valid/ready) takes one quaternion word x, y, z, w per
// cycle while quat_ready is high. Output channel euler (valid/ready) gives
// pitch, yaw and roll in 1/64 degree, reduced toward zero modulo 360, and a
// pole code. Throughput: one word per cycle, sustained while the receiver keeps euler_ready high.
// Pipeline: five product/sum stages, 31 square-root stages, 4 + CORDIC_ITERS
// atan2 stages (fold, normalize, CORDIC steps), two angle-reduction stages
// and the output queue.
// The pipeline advances as a whole while the two-word output queue has room,
// so a stalled receiver holds every word in place; quat_ready drops only when
// the queue is full and comes back the cycle after a word is taken.
// Reset clears the valid bits and the queue; data registers are not reset.
`default_nettype none
module quaternion_to_euler_angles #(
	parameter int CORDIC_ITERS    = qte_pkg::CORDIC_ITERS_DEF,
	parameter int COMPONENT_WIDTH = qte_pkg::COMPONENT_WIDTH_DEF
) (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            quat_valid,
	output logic                 quat_ready,
	input  wire qte_pkg::quat_t  quat,
	output logic                 euler_valid,
	input  wire logic            euler_ready,
	output qte_pkg::euler_t      euler
);
	localparam int AW    = qte_pkg::AW;
	localparam int ANG_W = qte_pkg::ANG_W;
	localparam int AW2   = ANG_W + 1;
	localparam int MAGW  = ANG_W;
	localparam int STEPS = qte_pkg::ISQ_STEPS;
	localparam int ALAT  = qte_pkg::NORM_LAT + CORDIC_ITERS;
	localparam int LW    = (COMPONENT_WIDTH > 16) ? COMPONENT_WIDTH : 16;

	typedef struct packed {
		logic [1:0]         pole;
		logic signed [31:0] s;
		logic signed [35:0] yn;
		logic signed [35:0] yd;
		logic signed [35:0] rn;
		logic signed [35:0] rd;
		logic signed [15:0] px;
		logic signed [15:0] py;
	} side_t;

	typedef struct packed {
		logic            neg;
		logic [MAGW-1:0] mag;
	} mag_t;

	function automatic logic signed [15:0] load_q15(input logic signed [15:0] c);
		logic [LW-1:0]                     ext;
		logic signed [COMPONENT_WIDTH-1:0] raw;
		logic signed [15:0]                t;
		ext = LW'($unsigned(c));
		raw = $signed(ext[COMPONENT_WIDTH-1:0]);
		if (COMPONENT_WIDTH >= 16)
			t = 16'(raw >>> ((COMPONENT_WIDTH >= 16) ? COMPONENT_WIDTH - 16 : 0));
		else
			t = 16'(raw) <<< ((COMPONENT_WIDTH < 16) ? 16 - COMPONENT_WIDTH : 0);
		return t;
	endfunction

	function automatic mag_t to_mag(input logic signed [AW2-1:0] a);
		mag_t m;
		m.neg = a[AW2-1];
		m.mag = a[AW2-1] ? MAGW'(-a) : MAGW'(a);
		return m;
	endfunction

	function automatic logic signed [15:0] to_out(input mag_t m);
		logic [MAGW-1:0] r;
		logic [15:0]     q;
		r = (m.mag >= MAGW'(qte_pkg::FULL_TURN)) ? m.mag - MAGW'(qte_pkg::FULL_TURN) : m.mag;
		q = 16'(r >> qte_pkg::OUT_SHIFT);
		return m.neg ? -$signed(q) : $signed(q);
	endfunction

	logic en;
	logic push, pop;
	logic [1:0] cnt_q;
	logic wr_q, rd_q;
	qte_pkg::euler_t fq [0:1];

	assign en         = (cnt_q != 2'd2);
	assign quat_ready = en;

	// stage 1: load and products
	logic signed [15:0] lx, ly, lz, lw;
	assign lx = load_q15(quat.quat_x);
	assign ly = load_q15(quat.quat_y);
	assign lz = load_q15(quat.quat_z);
	assign lw = load_q15(quat.quat_w);

	logic vld_s1, vld_s2, vld_s3, vld_s4, vld_s5;
	logic signed [15:0] qx_s1, qy_s1, qx_s2, qy_s2;
	logic signed [31:0] xx_s1, yy_s1, zz_s1, ww_s1;
	logic signed [31:0] xw_s1, yz_s1, wy_s1, zx_s1, wz_s1, xy_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
		end else if (en) begin
			vld_s1 <= quat_valid;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
			vld_s5 <= vld_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			qx_s1 <= lx;
			qy_s1 <= ly;
			xx_s1 <= lx * lx;
			yy_s1 <= ly * ly;
			zz_s1 <= lz * lz;
			ww_s1 <= lw * lw;
			xw_s1 <= lx * lw;
			yz_s1 <= ly * lz;
			wy_s1 <= lw * ly;
			zx_s1 <= lz * lx;
			wz_s1 <= lw * lz;
			xy_s1 <= lx * ly;
		end
	end

	// stage 2: norm, pole test, atan2 operands
	logic signed [33:0] unit_s2;
	logic signed [32:0] test_s2;
	logic signed [35:0] yn_s2, yd_s2, rn_s2, rd_s2;

	always_ff @(posedge clk) begin
		if (en) begin
			qx_s2   <= qx_s1;
			qy_s2   <= qy_s1;
			unit_s2 <= 34'(xx_s1) + 34'(yy_s1) + 34'(zz_s1) + 34'(ww_s1);
			test_s2 <= 33'(xw_s1) - 33'(yz_s1);
			yn_s2   <= (36'(wy_s1) + 36'(zx_s1)) <<< 1;
			yd_s2   <= 36'(qte_pkg::Q30_ONE) - ((36'(xx_s1) + 36'(yy_s1)) <<< 1);
			rn_s2   <= (36'(wz_s1) + 36'(xy_s1)) <<< 1;
			rd_s2   <= 36'(qte_pkg::Q30_ONE) - ((36'(zz_s1) + 36'(xx_s1)) <<< 1);
		end
	end

	// stage 3: pole decision, clamped asin argument
	logic signed [47:0] tl, ur;
	logic signed [33:0] s2x;
	logic signed [31:0] s_sat;
	logic [1:0]         pole_c;
	side_t              side_s3, side_s4, side_s5;
	logic [30:0]        smag_s3;
	logic [61:0]        sq_s4;
	logic [60:0]        rad_s5;

	always_comb begin
		tl  = 48'(test_s2) * 48'sd2000;
		ur  = 48'(unit_s2) * 48'sd999;
		s2x = 34'(test_s2) <<< 1;
		if (tl > ur)
			pole_c = qte_pkg::POLE_NORTH;
		else if (tl < -ur)
			pole_c = qte_pkg::POLE_SOUTH;
		else
			pole_c = qte_pkg::POLE_NONE;
		if (s2x > 34'(qte_pkg::Q30_ONE))
			s_sat = 32'(qte_pkg::Q30_ONE);
		else if (s2x < -34'(qte_pkg::Q30_ONE))
			s_sat = -32'(qte_pkg::Q30_ONE);
		else
			s_sat = 32'(s2x);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_s3.pole <= pole_c;
			side_s3.s    <= s_sat;
			side_s3.yn   <= yn_s2;
			side_s3.yd   <= yd_s2;
			side_s3.rn   <= rn_s2;
			side_s3.rd   <= rd_s2;
			side_s3.px   <= qx_s2;
			side_s3.py   <= qy_s2;
			smag_s3      <= s_sat[31] ? 31'(-s_sat) : 31'(s_sat);
		end
	end

	// stages 4 and 5: radicand 1 - s*s in Q60
	always_ff @(posedge clk) begin
		if (en) begin
			side_s4 <= side_s3;
			sq_s4   <= smag_s3 * smag_s3;
			side_s5 <= side_s4;
			rad_s5  <= (61'(1) << 60) - 61'(sq_s4);
		end
	end

	logic [30:0] root;

	qte_isqrt u_isqrt (
		.clk  (clk),
		.en   (en),
		.rad  (rad_s5),
		.root (root)
	);

	// side words ride alongside the square root
	side_t sd_s [0:STEPS-1];
	logic  sv_s [0:STEPS-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < STEPS; k++) sv_s[k] <= 1'b0;
		end else if (en) begin
			sv_s[0] <= vld_s5;
			for (int k = 1; k < STEPS; k++) sv_s[k] <= sv_s[k-1];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sd_s[0] <= side_s5;
			for (int k = 1; k < STEPS; k++) sd_s[k] <= sd_s[k-1];
		end
	end

	side_t sd_e;
	logic signed [AW-1:0] pit_y, pit_x, yaw_y, yaw_x, rol_y, rol_x;

	always_comb begin
		sd_e  = sd_s[STEPS-1];
		pit_y = AW'(sd_e.s);
		pit_x = $signed(AW'(root));
		if (sd_e.pole != qte_pkg::POLE_NONE) begin
			yaw_y = AW'(sd_e.py);
			yaw_x = AW'(sd_e.px);
		end else begin
			yaw_y = sd_e.yn;
			yaw_x = sd_e.yd;
		end
		rol_y = sd_e.rn;
		rol_x = sd_e.rd;
	end

	logic signed [ANG_W-1:0] pa, ya, ra;

	qte_atan2 #(.ITERS(CORDIC_ITERS)) u_pitch (
		.clk (clk), .en (en), .y (pit_y), .x (pit_x), .angle (pa)
	);

	qte_atan2 #(.ITERS(CORDIC_ITERS)) u_yaw (
		.clk (clk), .en (en), .y (yaw_y), .x (yaw_x), .angle (ya)
	);

	qte_atan2 #(.ITERS(CORDIC_ITERS)) u_roll (
		.clk (clk), .en (en), .y (rol_y), .x (rol_x), .angle (ra)
	);

	logic [1:0] pd_s [0:ALAT-1];
	logic       pv_s [0:ALAT-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < ALAT; k++) pv_s[k] <= 1'b0;
		end else if (en) begin
			pv_s[0] <= sv_s[STEPS-1];
			for (int k = 1; k < ALAT; k++) pv_s[k] <= pv_s[k-1];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			pd_s[0] <= sd_e.pole;
			for (int k = 1; k < ALAT; k++) pd_s[k] <= pd_s[k-1];
		end
	end

	// stage 6: pole overrides, sign and magnitude
	logic [1:0]          pole_e;
	logic signed [AW2-1:0] pit_v, yaw_v, rol_v, ya2;
	logic                vld_s6, vld_s7;
	logic [1:0]          pole_s6;
	mag_t                pm_s6, ym_s6, rm_s6;
	qte_pkg::euler_t     res_s7;

	always_comb begin
		pole_e = pd_s[ALAT-1];
		ya2    = AW2'(ya) <<< 1;
		case (pole_e)
			qte_pkg::POLE_NORTH: begin
				pit_v = AW2'(qte_pkg::DEG90);
				yaw_v = ya2;
				rol_v = '0;
			end
			qte_pkg::POLE_SOUTH: begin
				pit_v = -AW2'(qte_pkg::DEG90);
				yaw_v = -ya2;
				rol_v = '0;
			end
			default: begin
				pit_v = AW2'(pa);
				yaw_v = AW2'(ya);
				rol_v = AW2'(ra);
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s6 <= 1'b0;
			vld_s7 <= 1'b0;
		end else if (en) begin
			vld_s6 <= pv_s[ALAT-1];
			vld_s7 <= vld_s6;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			pole_s6 <= pole_e;
			pm_s6   <= to_mag(pit_v);
			ym_s6   <= to_mag(yaw_v);
			rm_s6   <= to_mag(rol_v);
			// stage 7: modulo 360 toward zero, 1/64 degree
			res_s7.angle_x   <= to_out(pm_s6);
			res_s7.angle_y   <= to_out(ym_s6);
			res_s7.angle_z   <= to_out(rm_s6);
			res_s7.pole_case <= pole_s6;
		end
	end

	// two-word output queue decouples the receiver from the pipeline
	assign push        = en && vld_s7;
	assign pop         = euler_valid && euler_ready;
	assign euler_valid = (cnt_q != 2'd0);
	assign euler       = fq[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 2'd0;
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
		end else begin
			if (push) wr_q <= ~wr_q;
			if (pop)  rd_q <= ~rd_q;
			case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 2'd1;
				2'b01:   cnt_q <= cnt_q - 2'd1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (push) fq[wr_q] <= res_s7;
	end

endmodule
`default_nettype wire
